### rtl/cssc_pkg.sv
// Shared constants, codes and helpers for the clock / stopwatch controller.
// No dependencies; every other file in rtl/ imports this package.

package cssc_pkg;

    // field widths
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int TENTH_W  = 4;
    localparam int MODE_W   = 3;
    localparam int FSM_W    = 2;
    localparam int PERIOD_W = 2;
    localparam int DIV_W    = 4;
    localparam int HOLD_W   = 8;
    localparam int SPAN_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPAN    = 1'b1;

    // configuration reset values
    localparam logic [HOLD_W-1:0] HOLD_THRESHOLD_RST = 8'd50;
    localparam logic [SPAN_W-1:0] REPEAT_SPAN_RST    = 4'd10;

    // item kinds
    localparam logic FUNC_BUTTON = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // field modes
    localparam logic [MODE_W-1:0] MODE_SHOW      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET_HOUR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_MIN   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_SEC   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOPWATCH = 3'd4;

    // timer period codes
    localparam logic [PERIOD_W-1:0] PERIOD_1000MS = 2'd0;
    localparam logic [PERIOD_W-1:0] PERIOD_250MS  = 2'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_100MS  = 2'd2;

    // wrap limits
    localparam logic [HOUR_W-1:0]  HOURS_PER_DAY   = 5'd24;
    localparam logic [MIN_W-1:0]   MINS_PER_HOUR   = 6'd60;
    localparam logic [SEC_W-1:0]   SECS_PER_MIN    = 6'd60;
    localparam logic [TENTH_W-1:0] TENTHS_PER_SEC  = 4'd10;

    // debounced button view handed to the mode machine
    typedef struct packed {
        logic                press_one;
        logic                press_two;
        logic                repeat_on;
        logic [SPAN_W-1:0]   repeat_count;
    } btn_status_t;

    // timer ticks per second for each period code
    function automatic logic [DIV_W-1:0] ticks_per_second(input logic [PERIOD_W-1:0] period);
        logic [DIV_W-1:0] tps;
        case (period)
            PERIOD_1000MS: tps = 4'd1;
            PERIOD_250MS:  tps = 4'd4;
            PERIOD_100MS:  tps = 4'd10;
            default:       tps = 4'd1;
        endcase
        return tps;
    endfunction

endpackage

### rtl/cssc_if.sv
// Valid/ready channel interfaces for the clock / stopwatch controller.
// Depends on cssc_pkg for field widths.

interface cssc_item_if;
    import cssc_pkg::*;

    logic valid;
    logic ready;
    logic func;
    logic button_one_level;
    logic button_two_level;

    modport source (output valid, func, button_one_level, button_two_level, input ready);
    modport sink   (input valid, func, button_one_level, button_two_level, output ready);
endinterface

interface cssc_result_if;
    import cssc_pkg::*;

    logic                valid;
    logic                ready;
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
    logic [SEC_W-1:0]    seconds;
    logic [MIN_W-1:0]    sw_minutes;
    logic [SEC_W-1:0]    sw_seconds;
    logic [TENTH_W-1:0]  sw_tenths;
    logic [MODE_W-1:0]   field_mode;
    logic [FSM_W-1:0]    machine_state;
    logic                blink_on;
    logic [PERIOD_W-1:0] tick_period_sel;
    logic                stopwatch_running;

    modport source (output valid, hours, minutes, seconds, sw_minutes, sw_seconds,
                    sw_tenths, field_mode, machine_state, blink_on, tick_period_sel,
                    stopwatch_running, input ready);
    modport sink   (input valid, hours, minutes, seconds, sw_minutes, sw_seconds,
                    sw_tenths, field_mode, machine_state, blink_on, tick_period_sel,
                    stopwatch_running, output ready);
endinterface

### rtl/cssc_buttons.sv
// Button debounce with hold counting and auto-repeat for the adjust button.
// Depends on cssc_pkg (widths, btn_status_t).

module cssc_buttons (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample,
    input  logic                         button_one_level,
    input  logic                         button_two_level,
    input  logic [cssc_pkg::HOLD_W-1:0]  hold_threshold,
    input  logic [cssc_pkg::SPAN_W-1:0]  repeat_span,
    output cssc_pkg::btn_status_t        status
);
    import cssc_pkg::*;

    logic [1:0]        hist_one_reg, hist_one_next;
    logic [1:0]        hist_two_reg, hist_two_next;
    logic [HOLD_W-1:0] hold_count_reg, hold_count_next;
    logic [SPAN_W-1:0] repeat_count_reg, repeat_count_next;
    logic [HOLD_W-1:0] hold_inc;
    logic [SPAN_W-1:0] repeat_base;
    logic              press_one, press_two, repeat_on;

    // two-sample debounce, newest sample in bit 0
    assign hist_one_next = {hist_one_reg[0], button_one_level};
    assign hist_two_next = {hist_two_reg[0], button_two_level};
    assign press_one = (hist_one_next == 2'b00);
    assign press_two = (hist_two_next == 2'b00) && !press_one;

    // hold counter saturates at the threshold, then repeat counting runs
    assign hold_inc    = (hold_count_reg < hold_threshold) ? hold_count_reg + 1'b1
                                                           : hold_count_reg;
    assign repeat_base = (repeat_count_reg >= repeat_span) ? '0 : repeat_count_reg;

    always_comb
    begin
        repeat_on         = 1'b0;
        hold_count_next   = '0;
        repeat_count_next = '0;
        if (press_two)
        begin
            hold_count_next   = hold_inc;
            repeat_count_next = repeat_count_reg;
            if (hold_inc >= hold_threshold)
            begin
                repeat_on         = 1'b1;
                repeat_count_next = repeat_base + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_one_reg     <= '0;
            hist_two_reg     <= '0;
            hold_count_reg   <= '0;
            repeat_count_reg <= '0;
        end
        else if (sample)
        begin
            hist_one_reg     <= hist_one_next;
            hist_two_reg     <= hist_two_next;
            hold_count_reg   <= hold_count_next;
            repeat_count_reg <= repeat_count_next;
        end
    end

    assign status.press_one    = press_one;
    assign status.press_two    = press_two;
    assign status.repeat_on    = repeat_on;
    assign status.repeat_count = repeat_count_next;

endmodule

### rtl/clock_set_stopwatch_controller.sv
// Top level of the clock / stopwatch controller: item register, mode machine,
// time keeping and result handshake. Depends on cssc_pkg, cssc_if, cssc_buttons.
//
// Usage
//   item channel: func 0 carries a button sample (two active-low levels),
//   func 1 is a timer tick. Every accepted item yields exactly one result on
//   the result channel: time of day, stopwatch, field mode, machine state,
//   blink phase, wanted timer period and stopwatch run flag, all taken after
//   the item's update.
//   Configuration: cfg_write with cfg_index 0 sets the hold threshold, index 1
//   the repeat span (low 4 bits of cfg_data). Write only while idle.
// Item flow and throughput
//   An item is captured in the item register and applied by the update pass
//   into the state registers. One item per cycle is sustained while results
//   are taken; the single update pass through the mode machine and the time
//   carry chain sets that figure.
// Reset
//   Time and stopwatch read zero, mode show, blink phase 1, period 1000 ms,
//   hold threshold 50, repeat span 10, button history low.
// Stall
//   The state registers double as the result register. While a result waits
//   one more item is held in the item register; then item ready drops.

module clock_set_stopwatch_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    cssc_item_if.sink                       item,
    cssc_result_if.source                   result,
    input  logic                            cfg_write,
    input  logic [cssc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cssc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cssc_pkg::*;

    typedef enum logic [FSM_W-1:0] {
        ST_REGULAR   = 2'd0,
        ST_INCREASE  = 2'd1,
        ST_MODIFY    = 2'd2,
        ST_STOPWATCH = 2'd3
    } fsm_state_t;

    // configuration
    logic [HOLD_W-1:0] hold_threshold_reg;
    logic [SPAN_W-1:0] repeat_span_reg;

    // item register and handshake
    logic item_valid_reg;
    logic func_reg, b1_reg, b2_reg;
    logic res_valid_reg;
    logic step, item_xfer, button_step, tick_step;

    // block state
    fsm_state_t          fsm_state_reg, fsm_state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MIN_W-1:0]    minute_reg, minute_next;
    logic [SEC_W-1:0]    second_reg, second_next;
    logic [MIN_W-1:0]    sw_minute_reg, sw_minute_next;
    logic [SEC_W-1:0]    sw_second_reg, sw_second_next;
    logic [TENTH_W-1:0]  sw_tenth_reg, sw_tenth_next;
    logic [DIV_W-1:0]    div_count_reg, div_count_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                blink_reg, blink_next;
    logic                running_reg, running_next;
    logic                guard_mode_reg, guard_mode_next;
    logic                guard_sw_reg, guard_sw_next;
    logic                guard_rep_reg, guard_rep_next;

    btn_status_t btn;

    // helpers for the update pass
    logic [HOUR_W-1:0]  hour_inc, hour_bump;
    logic [MIN_W-1:0]   minute_inc, minute_bump;
    logic [SEC_W-1:0]   second_inc, second_bump;
    logic [MODE_W-1:0]  mode_inc;
    logic [DIV_W-1:0]   div_inc;

    assign item_xfer   = item.valid && item.ready;
    assign step        = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready  = !item_valid_reg || step;
    assign button_step = step && (func_reg == FUNC_BUTTON);
    assign tick_step   = step && (func_reg == FUNC_TICK);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_threshold_reg <= HOLD_THRESHOLD_RST;
            repeat_span_reg    <= REPEAT_SPAN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HOLD_THRESHOLD: hold_threshold_reg <= cfg_data;
                REG_REPEAT_SPAN:    repeat_span_reg    <= cfg_data[SPAN_W-1:0];
                default:            ;
            endcase
        end
    end

    // item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_xfer)
                item_valid_reg <= 1'b1;
            else if (step)
                item_valid_reg <= 1'b0;
            if (step)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            func_reg <= item.func;
            b1_reg   <= item.button_one_level;
            b2_reg   <= item.button_two_level;
        end
    end

    // debounce and auto-repeat
    cssc_buttons u_buttons (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample           (button_step),
        .button_one_level (b1_reg),
        .button_two_level (b2_reg),
        .hold_threshold   (hold_threshold_reg),
        .repeat_span      (repeat_span_reg),
        .status           (btn)
    );

    // wrapped increments used by field set
    assign hour_inc    = hour_reg + 1'b1;
    assign minute_inc  = minute_reg + 1'b1;
    assign second_inc  = second_reg + 1'b1;
    assign hour_bump   = (hour_inc >= HOURS_PER_DAY) ? '0 : hour_inc;
    assign minute_bump = (minute_inc >= MINS_PER_HOUR) ? '0 : minute_inc;
    assign second_bump = (second_inc >= SECS_PER_MIN) ? '0 : second_inc;
    assign mode_inc    = mode_reg + 1'b1;
    assign div_inc     = div_count_reg + 1'b1;

    // single update pass: button sample or timer tick
    always_comb
    begin
        fsm_state_next  = fsm_state_reg;
        mode_next       = mode_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        sw_minute_next  = sw_minute_reg;
        sw_second_next  = sw_second_reg;
        sw_tenth_next   = sw_tenth_reg;
        div_count_next  = div_count_reg;
        period_next     = period_reg;
        blink_next      = blink_reg;
        running_next    = running_reg;
        guard_mode_next = guard_mode_reg;
        guard_sw_next   = guard_sw_reg;
        guard_rep_next  = guard_rep_reg;

        if (button_step)
        begin
            case (fsm_state_reg)
                ST_REGULAR:
                begin
                    if (btn.press_one)
                    begin
                        if (guard_mode_reg)
                        begin
                            fsm_state_next  = ST_INCREASE;
                            mode_next       = MODE_SET_HOUR;
                            period_next     = PERIOD_250MS;
                            guard_mode_next = 1'b0;
                        end
                    end
                    else
                        guard_mode_next = 1'b1;
                end
                ST_INCREASE:
                begin
                    if (btn.press_one)
                    begin
                        if (guard_mode_reg)
                        begin
                            mode_next = mode_inc;
                            if (mode_inc == MODE_STOPWATCH)
                            begin
                                fsm_state_next = ST_STOPWATCH;
                                period_next    = PERIOD_100MS;
                            end
                            guard_mode_next = 1'b0;
                        end
                    end
                    else
                        guard_mode_next = 1'b1;
                    // single increment on the press of the adjust button
                    if (btn.press_two)
                    begin
                        if (mode_reg == MODE_SET_HOUR)
                            hour_next = hour_bump;
                        else if (mode_reg == MODE_SET_MIN)
                            minute_next = minute_bump;
                        else if (mode_reg == MODE_SET_SEC)
                            second_next = second_bump;
                        fsm_state_next = ST_MODIFY;
                    end
                end
                ST_MODIFY:
                begin
                    if (!btn.press_two)
                        fsm_state_next = ST_INCREASE;
                    // auto-repeat fires once per span, re-armed in between
                    if (btn.repeat_on)
                    begin
                        if (btn.repeat_count == repeat_span_reg)
                        begin
                            if (guard_rep_reg)
                            begin
                                guard_rep_next = 1'b0;
                                if (mode_reg == MODE_SET_HOUR)
                                    hour_next = hour_bump;
                                else if (mode_reg == MODE_SET_MIN)
                                    minute_next = minute_bump;
                                else if (mode_reg == MODE_SET_SEC)
                                    second_next = second_bump;
                            end
                        end
                        else
                            guard_rep_next = 1'b1;
                    end
                end
                ST_STOPWATCH:
                begin
                    if (btn.press_two)
                    begin
                        if (guard_sw_reg)
                        begin
                            guard_sw_next = 1'b0;
                            running_next  = !running_reg;
                        end
                    end
                    else
                        guard_sw_next = 1'b1;
                    if (btn.press_one)
                    begin
                        if (guard_mode_reg)
                        begin
                            fsm_state_next  = ST_REGULAR;
                            mode_next       = MODE_SHOW;
                            sw_minute_next  = '0;
                            sw_second_next  = '0;
                            sw_tenth_next   = '0;
                            period_next     = PERIOD_1000MS;
                            guard_mode_next = 1'b0;
                        end
                    end
                    else
                        guard_mode_next = 1'b1;
                end
                default:
                    fsm_state_next = ST_REGULAR;
            endcase
        end
        else if (tick_step)
        begin
            // divider down to one second
            if (div_inc >= ticks_per_second(period_reg))
            begin
                second_next    = second_inc;
                div_count_next = '0;
            end
            else
                div_count_next = div_inc;
            if (mode_reg == MODE_STOPWATCH && running_reg)
                sw_tenth_next = sw_tenth_reg + 1'b1;
            blink_next = !blink_reg;
            // time of day carries
            if (second_next >= SECS_PER_MIN)
            begin
                minute_next = minute_inc;
                second_next = '0;
            end
            if (minute_next >= MINS_PER_HOUR)
            begin
                hour_next   = hour_inc;
                minute_next = '0;
            end
            if (hour_next >= HOURS_PER_DAY)
                hour_next = '0;
            // stopwatch carries
            if (mode_reg == MODE_STOPWATCH)
            begin
                if (sw_tenth_next >= TENTHS_PER_SEC)
                begin
                    sw_second_next = sw_second_reg + 1'b1;
                    sw_tenth_next  = '0;
                end
                if (sw_second_next >= SECS_PER_MIN)
                begin
                    sw_minute_next = sw_minute_reg + 1'b1;
                    sw_second_next = '0;
                end
                if (sw_minute_next >= MINS_PER_HOUR)
                    sw_minute_next = '0;
            end
        end
    end

    // state, also the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_state_reg  <= ST_REGULAR;
            mode_reg       <= MODE_SHOW;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
            sw_minute_reg  <= '0;
            sw_second_reg  <= '0;
            sw_tenth_reg   <= '0;
            div_count_reg  <= '0;
            period_reg     <= PERIOD_1000MS;
            blink_reg      <= 1'b1;
            running_reg    <= 1'b0;
            guard_mode_reg <= 1'b1;
            guard_sw_reg   <= 1'b1;
            guard_rep_reg  <= 1'b1;
        end
        else if (step)
        begin
            fsm_state_reg  <= fsm_state_next;
            mode_reg       <= mode_next;
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            sw_minute_reg  <= sw_minute_next;
            sw_second_reg  <= sw_second_next;
            sw_tenth_reg   <= sw_tenth_next;
            div_count_reg  <= div_count_next;
            period_reg     <= period_next;
            blink_reg      <= blink_next;
            running_reg    <= running_next;
            guard_mode_reg <= guard_mode_next;
            guard_sw_reg   <= guard_sw_next;
            guard_rep_reg  <= guard_rep_next;
        end
    end

    // result channel
    assign result.valid             = res_valid_reg;
    assign result.hours             = hour_reg;
    assign result.minutes           = minute_reg;
    assign result.seconds           = second_reg;
    assign result.sw_minutes        = sw_minute_reg;
    assign result.sw_seconds        = sw_second_reg;
    assign result.sw_tenths         = sw_tenth_reg;
    assign result.field_mode        = mode_reg;
    assign result.machine_state     = fsm_state_reg;
    assign result.blink_on          = blink_reg;
    assign result.tick_period_sel   = period_reg;
    assign result.stopwatch_running = running_reg;

    // time-of-day fields and stopwatch tenths stay in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        hour_reg < HOURS_PER_DAY && minute_reg < MINS_PER_HOUR &&
        second_reg < SECS_PER_MIN && sw_tenth_reg < TENTHS_PER_SEC)
        else $error("time or stopwatch field out of range");

    // machine state and field mode agree
    a_mode_state: assert property (@(posedge clk) disable iff (!rst_n)
        ((fsm_state_reg == ST_STOPWATCH) == (mode_reg == MODE_STOPWATCH)) &&
        ((fsm_state_reg == ST_REGULAR) == (mode_reg == MODE_SHOW)))
        else $error("machine state and field mode disagree");

    // timer period follows the mode
    a_period_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ((mode_reg == MODE_STOPWATCH) == (period_reg == PERIOD_100MS)) &&
        ((mode_reg == MODE_SHOW) == (period_reg == PERIOD_1000MS)))
        else $error("timer period does not match mode");

    // a held item with a free result slot is applied at once
    a_item_applied: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !res_valid_reg |=> res_valid_reg)
        else $error("held item not applied");

endmodule
